@@ sv/tcw_pkg.sv @@
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared types and codes for the text console character writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

	// action codes
	localparam logic [1:0] ACT_PUT   = 2'd0;
	localparam logic [1:0] ACT_CLEAR = 2'd1;
	localparam logic [1:0] ACT_READ  = 2'd2;

	// character codes
	localparam logic [7:0] CH_BS    = 8'h08;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_DEL   = 8'h7F;

	// attribute after reset: white on black
	localparam logic [7:0] ATTR_RESET = 8'h0F;

	typedef enum logic [2:0] {
		CK_OTHER,
		CK_BS,
		CK_TAB,
		CK_CR,
		CK_LF,
		CK_PRINT
	} char_kind_t;

	typedef enum logic [1:0] {
		ALU_ADD,
		ALU_SUB
	} alu_op_t;

	function automatic char_kind_t char_kind(input logic [7:0] ch);
		char_kind_t k;
		k = CK_OTHER;
		case (ch)
			CH_BS:   k = CK_BS;
			CH_TAB:  k = CK_TAB;
			CH_CR:   k = CK_CR;
			CH_LF:   k = CK_LF;
			default: begin
				if (ch inside {[CH_SPACE:CH_DEL]}) k = CK_PRINT;
				else k = CK_OTHER;
			end
		endcase
		return k;
	endfunction

endpackage

@@ sv/tcw_ram.sv @@
// ----------------------------------------------------------------------------
// tcw_ram
// Generic memory, one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tcw_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end

endmodule

@@ sv/tcw_alu.sv @@
// ----------------------------------------------------------------------------
// tcw_alu
// Shared adder/subtractor used for cell addresses, cursor steps and sweeps.
// ----------------------------------------------------------------------------
module tcw_alu #(
	parameter int W = 11
) (
	input  tcw_pkg::alu_op_t op,
	input  logic [W-1:0]     a,
	input  logic [W-1:0]     b,
	output logic [W-1:0]     sum
);

	import tcw_pkg::*;

	logic         sub;
	logic [W-1:0] b_eff;

	always_comb begin
		sub   = (op == ALU_SUB);
		b_eff = sub ? ~b : b;
		sum   = a + b_eff + W'(sub);
	end

endmodule

@@ sv/text_console_char_writer.sv @@
// ----------------------------------------------------------------------------
// text_console_char_writer
// Character-cell console: screen store, cursor, put/clear/read actions.
// ----------------------------------------------------------------------------
// The block holds a ROWS x COLUMNS screen of 16-bit cells (character in the
// low byte, attribute in the high byte) in one memory, and a cursor. Each
// input transfer carries one action; each action returns exactly one result
// transfer with the cursor after the action and, for a read, the cell. All
// work runs through a small sequencer that drives one shared adder and the
// single write port of the screen memory, and the block takes no new input
// while an action is in progress. Steps per action, from input transfer to
// result ready: a put passes S_PUT, S_MOVE and S_POS, plus S_ROW when the
// cursor moves to a new row; a read passes S_READ, S_RDATA and S_POS; a
// clear writes every cell, one cell written per cycle; a put that scrolls
// adds a copy of the rows below the top (a read then a write per cell) and
// a blanking of the bottom row. After reset a clearing pass blanks the
// screen with attribute 0x0F before the first input is taken; configuration
// writes are taken at any time, and cfg_ready is always high. The attribute
// register is to be written only while the block is idle.
// ----------------------------------------------------------------------------
module text_console_char_writer #(
	parameter int COLUMNS   = 80,
	parameter int ROWS      = 25,
	parameter int TAB_WIDTH = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration write channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_data,
	// input channel
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  action,
	input  logic [7:0]  char_code,
	input  logic [10:0] cell_address,
	// result channel
	output logic        out_valid,
	input  logic        out_ready,
	output logic [10:0] cursor_position,
	output logic [4:0]  cursor_row,
	output logic [6:0]  cursor_column,
	output logic [15:0] cell_data
);

	import tcw_pkg::*;

	localparam int CELLS = ROWS * COLUMNS;
	localparam int AW    = $clog2(CELLS);
	localparam int CW    = $clog2(COLUMNS);
	localparam int RW    = $clog2(ROWS);
	localparam int GW    = $clog2(TAB_WIDTH + 1);
	localparam int CXW   = $clog2(COLUMNS + TAB_WIDTH);
	localparam int W     = (AW > CXW) ? AW : CXW;
	localparam int CMPW  = (AW > 11) ? AW : 11;

	localparam logic [AW-1:0] LAST_CELL   = AW'(CELLS - 1);
	localparam logic [AW-1:0] COPY_LAST   = AW'((ROWS - 1) * COLUMNS - 1);
	localparam logic [AW-1:0] BOTTOM_BASE = AW'((ROWS - 1) * COLUMNS);
	localparam logic [RW-1:0] ROW_LAST    = RW'(ROWS - 1);
	localparam logic [GW-1:0] GAP_FULL    = GW'(TAB_WIDTH);

	// one-hot sequencer states
	typedef enum logic [9:0] {
		S_IDLE  = 10'b0000000001,
		S_PUT   = 10'b0000000010,
		S_MOVE  = 10'b0000000100,
		S_ROW   = 10'b0000001000,
		S_SRD   = 10'b0000010000,
		S_SWR   = 10'b0000100000,
		S_CLR   = 10'b0001000000,
		S_READ  = 10'b0010000000,
		S_RDATA = 10'b0100000000,
		S_POS   = 10'b1000000000
	} state_t;

	state_t        state_q;
	logic [7:0]    attr_q;        // text attribute register
	logic [7:0]    blank_attr_q;  // attribute used by the current blanking sweep
	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic [AW-1:0] base_q;        // row_q * COLUMNS, kept by additions
	logic [GW-1:0] gap_q;         // distance to the next tab stop, 1..TAB_WIDTH
	logic [AW-1:0] ptr_q;         // sweep pointer for clear and scroll
	logic          resp_pend_q;   // sweep belongs to an action, so report after it
	logic          out_valid_q;

	// per-action payload
	char_kind_t    kind_q;
	logic [7:0]    char_q;
	logic [10:0]   addr_q;
	logic          in_range_q;
	logic [15:0]   data_q;

	// result register
	logic [10:0]   pos_out_q;
	logic [4:0]    row_out_q;
	logic [6:0]    col_out_q;
	logic [15:0]   data_out_q;

	// shared adder
	alu_op_t       alu_op;
	logic [W-1:0]  alu_a;
	logic [W-1:0]  alu_b;
	logic [W-1:0]  alu_sum;

	// screen memory ports
	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [15:0]   mem_wdata;
	logic [AW-1:0] mem_raddr;
	logic [15:0]   mem_rdata;

	logic          in_xfer;
	logic          out_free;
	logic [CXW-1:0] new_col;
	logic          wrap;

	assign cfg_ready       = 1'b1;
	assign in_ready        = (state_q == S_IDLE);
	assign in_xfer         = in_valid && in_ready;
	assign out_valid       = out_valid_q;
	assign out_free        = !out_valid_q || out_ready;
	assign cursor_position = pos_out_q;
	assign cursor_row      = row_out_q;
	assign cursor_column   = col_out_q;
	assign cell_data       = data_out_q;

	assign new_col = alu_sum[CXW-1:0];
	assign wrap    = (new_col >= CXW'(COLUMNS));

	tcw_alu #(.W(W)) u_alu (
		.op  (alu_op),
		.a   (alu_a),
		.b   (alu_b),
		.sum (alu_sum)
	);

	tcw_ram #(.WIDTH(16), .DEPTH(CELLS)) u_screen (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// operand selection for the shared adder
	always_comb begin
		alu_op = ALU_ADD;
		alu_a  = '0;
		alu_b  = '0;
		case (state_q)
			S_PUT, S_POS: begin
				// cell index of the cursor
				alu_a = W'(base_q);
				alu_b = W'(col_q);
			end
			S_MOVE: begin
				alu_a = W'(col_q);
				case (kind_q)
					CK_PRINT: alu_b = W'(1);
					CK_TAB:   alu_b = W'(gap_q);
					CK_BS: begin
						alu_op = ALU_SUB;
						alu_b  = (col_q != '0) ? W'(1) : '0;
					end
					CK_CR, CK_LF: alu_a = '0;
					default:  alu_b = '0;
				endcase
			end
			S_ROW: begin
				alu_a = W'(base_q);
				alu_b = W'(COLUMNS);
			end
			S_SRD: begin
				// source cell one row below
				alu_a = W'(ptr_q);
				alu_b = W'(COLUMNS);
			end
			S_SWR, S_CLR: begin
				alu_a = W'(ptr_q);
				alu_b = W'(1);
			end
			default: begin
				alu_a = '0;
				alu_b = '0;
			end
		endcase
	end

	// screen memory access
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = ptr_q;
		mem_wdata = {blank_attr_q, CH_SPACE};
		mem_raddr = '0;
		case (state_q)
			S_PUT: begin
				mem_we    = (kind_q == CK_PRINT);
				mem_waddr = alu_sum[AW-1:0];
				mem_wdata = {attr_q, char_q};
			end
			S_SRD:  mem_raddr = alu_sum[AW-1:0];
			S_SWR: begin
				mem_we    = 1'b1;
				mem_wdata = mem_rdata;
			end
			S_CLR:  mem_we = 1'b1;
			S_READ: mem_raddr = AW'(addr_q);
			default: mem_we = 1'b0;
		endcase
	end

	// result valid: set when the cursor is reported, cleared by the transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_POS && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// sequencer and cursor
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLR;   // clearing pass after reset
			attr_q       <= ATTR_RESET;
			blank_attr_q <= ATTR_RESET;
			col_q        <= '0;
			row_q        <= '0;
			base_q       <= '0;
			gap_q        <= GAP_FULL;
			ptr_q        <= '0;
			resp_pend_q  <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) attr_q <= cfg_data;

			case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						case (action)
							ACT_PUT:  state_q <= S_PUT;
							ACT_CLEAR: begin
								col_q        <= '0;
								row_q        <= '0;
								base_q       <= '0;
								gap_q        <= GAP_FULL;
								ptr_q        <= '0;
								blank_attr_q <= attr_q;
								resp_pend_q  <= 1'b1;
								state_q      <= S_CLR;
							end
							ACT_READ: state_q <= S_READ;
							default:  state_q <= S_POS;
						endcase
					end
				end
				S_PUT: state_q <= S_MOVE;
				S_MOVE: begin
					col_q <= wrap ? '0 : new_col[CW-1:0];
					case (kind_q)
						CK_PRINT: gap_q <= (wrap || gap_q == GW'(1)) ? GAP_FULL : gap_q - GW'(1);
						CK_BS: begin
							if (col_q != '0) gap_q <= (gap_q == GAP_FULL) ? GW'(1) : gap_q + GW'(1);
						end
						CK_TAB, CK_CR, CK_LF: gap_q <= GAP_FULL;
						default: gap_q <= gap_q;
					endcase
					state_q <= (wrap || kind_q == CK_LF) ? S_ROW : S_POS;
				end
				S_ROW: begin
					if (row_q == ROW_LAST) begin
						// past the bottom: scroll, cursor stays on the last row
						ptr_q   <= '0;
						state_q <= S_SRD;
					end else begin
						row_q   <= row_q + RW'(1);
						base_q  <= alu_sum[AW-1:0];
						state_q <= S_POS;
					end
				end
				S_SRD: state_q <= S_SWR;
				S_SWR: begin
					if (ptr_q == COPY_LAST) begin
						ptr_q        <= BOTTOM_BASE;
						blank_attr_q <= attr_q;
						resp_pend_q  <= 1'b1;
						state_q      <= S_CLR;
					end else begin
						ptr_q   <= alu_sum[AW-1:0];
						state_q <= S_SRD;
					end
				end
				S_CLR: begin
					if (ptr_q == LAST_CELL) begin
						resp_pend_q <= 1'b0;
						state_q     <= resp_pend_q ? S_POS : S_IDLE;
					end else begin
						ptr_q <= alu_sum[AW-1:0];
					end
				end
				S_READ:  state_q <= S_RDATA;
				S_RDATA: state_q <= S_POS;
				S_POS: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// action payload and result register
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			char_q     <= char_code;
			kind_q     <= char_kind(char_code);
			addr_q     <= cell_address;
			in_range_q <= (CMPW'(cell_address) < CMPW'(CELLS));
			data_q     <= '0;
		end
		if (state_q == S_RDATA) data_q <= in_range_q ? mem_rdata : '0;
		if (state_q == S_POS && out_free) begin
			pos_out_q  <= 11'(alu_sum);
			row_out_q  <= 5'(row_q);
			col_out_q  <= 7'(col_q);
			data_out_q <= data_q;
		end
	end

endmodule
